// ----- rtl/core/aou_pkg.sv -----
// ----------------------------------------------------------------------------
// Adam update package
// Shared constants, stage indexes, register codes and helpers for the
// fixed-point Adam optimizer update pipeline.
// ----------------------------------------------------------------------------
package aou_pkg;

  // Width of the step counter that takes part in bias correction.
  localparam int STEP_BITS = 16;
  // Bits of the step count field that survive the mask.
  localparam int T_BITS = (STEP_BITS < 16) ? STEP_BITS : 16;

  // Latency of the shared building blocks, in register stages.
  localparam int DIV_LAT  = 34;
  localparam int SQRT_LAT = 29;

  // Stage numbers of the main pipeline; stage 1 holds the accepted request.
  localparam int K_DIV1_IN  = STEP_BITS + 2;
  localparam int K_DIV1_OUT = K_DIV1_IN + DIV_LAT;
  localparam int K_SQ_IN    = K_DIV1_OUT + 1;
  localparam int K_SQ_OUT   = K_SQ_IN + SQRT_LAT;
  localparam int K_DIV2_IN  = K_SQ_OUT + 1;
  localparam int K_DIV2_OUT = K_DIV2_IN + DIV_LAT;
  localparam int K_TOT      = K_DIV2_OUT + 1;
  localparam int K_LRP      = K_TOT + 1;
  localparam int K_OUT      = K_LRP + 1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BETA_FIRST    = 3'd0,
    REG_BETA_SECOND   = 3'd1,
    REG_LEARNING_RATE = 3'd2,
    REG_WEIGHT_DECAY  = 3'd3,
    REG_EPSILON       = 3'd4
  } cfg_reg_t;

  // Register defaults.
  localparam logic [15:0] RST_BETA_FIRST    = 16'd58982;
  localparam logic [15:0] RST_BETA_SECOND   = 16'd65470;
  localparam logic [23:0] RST_LEARNING_RATE = 24'd16777;
  localparam logic [23:0] RST_WEIGHT_DECAY  = 24'd0;
  localparam logic [23:0] RST_EPSILON       = 24'd1;

  // Unity in the two fixed-point formats used for the betas.
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [31:0] sat_s32(input logic signed [40:0] x);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- rtl/core/adam_optimizer_update.sv -----
// A request accepted into stage 1 reaches the output register through the
// beta power chain, two 34-stage dividers and the 29-stage square root.
// Throughput: one request per cycle; the whole pipeline holds while a
// result waits on m_tready.
// Reset clears every valid bit and loads the register defaults.
// ----------------------------------------------------------------------------
// Adam optimizer update
// Fixed-point Adam step with bias correction and L2 weight decay, one
// parameter per request.
// ----------------------------------------------------------------------------
module adam_optimizer_update (
  input  logic         clk,
  input  logic         rst,
  // weight_in, gradient, first_moment_in, second_moment_in, step_count
  input  logic [143:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // weight_out, first_moment_out, second_moment_out
  output logic [95:0]  m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import aou_pkg::*;

  typedef struct packed {
    logic [32:0]       acc1;
    logic [31:0]       base1;
    logic [32:0]       acc2;
    logic [31:0]       base2;
    logic [T_BITS-1:0] t;
  } pow_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] mn;
    logic [31:0]        vn;
    logic signed [33:0] wdt;
    logic signed [31:0] mhat;
    logic               neg;
    logic               zero;
  } side_t;

  // Configuration registers.
  logic [15:0] beta_first;
  logic [15:0] beta_second;
  logic [23:0] learning_rate;
  logic [23:0] weight_decay;
  logic [23:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_first    <= RST_BETA_FIRST;
      beta_second   <= RST_BETA_SECOND;
      learning_rate <= RST_LEARNING_RATE;
      weight_decay  <= RST_WEIGHT_DECAY;
      epsilon       <= RST_EPSILON;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BETA_FIRST:    beta_first    <= cfg_data[15:0];
        REG_BETA_SECOND:   beta_second   <= cfg_data[15:0];
        REG_LEARNING_RATE: learning_rate <= cfg_data;
        REG_WEIGHT_DECAY:  weight_decay  <= cfg_data;
        REG_EPSILON:       epsilon       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register can take a result.
  logic en;
  logic vld [1:K_OUT];

  assign en       = !vld[K_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[K_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= K_OUT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= K_OUT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: capture the request; a step of zero counts as one.
  logic signed [31:0] w1, g1, m1;
  logic [31:0]        v1;
  logic [T_BITS-1:0]  t1;
  logic [T_BITS-1:0]  t_in;

  assign t_in = s_tdata[128 +: T_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      w1 <= s_tdata[31:0];
      g1 <= s_tdata[63:32];
      m1 <= s_tdata[95:64];
      v1 <= s_tdata[127:96];
      t1 <= (t_in == '0) ? T_BITS'(1) : t_in;
    end
  end

  // Stage 2: the moment, gradient square and decay products.
  logic signed [49:0] pm1, pm2;
  logic [63:0]        gsq;
  logic signed [56:0] wdp;
  logic [47:0]        pv1_2;
  logic signed [31:0] w2;
  logic [31:0]        gmag;
  logic [16:0]        b1n;

  assign gmag = g1[31] ? 32'(-g1) : 32'(g1);
  assign b1n  = ONE_Q16 - {1'b0, beta_first};

  always_ff @(posedge clk) begin
    if (en) begin
      pm1   <= $signed({2'b00, beta_first}) * m1;
      pm2   <= $signed({1'b0, b1n}) * g1;
      gsq   <= gmag * gmag;
      wdp   <= $signed({1'b0, weight_decay}) * w1;
      pv1_2 <= beta_second * v1;
      w2    <= w1;
    end
  end

  // Stage 3: round the first moment, the gradient square and the decay term.
  logic signed [50:0] msum;
  logic signed [34:0] msh;
  logic signed [31:0] mn3;
  logic [39:0]        g2_3;
  logic signed [33:0] wdt3;
  logic signed [57:0] wdsum;
  logic [47:0]        pv1_3;
  logic signed [31:0] w3;

  assign msum  = 51'(pm1) + 51'(pm2) + 51'sd32768;
  assign msh   = 35'(msum >>> 16);
  assign wdsum = 58'(wdp) + 58'sh80_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      mn3   <= sat_s32(41'(msh));
      g2_3  <= 40'((gsq + 64'h80_0000) >> 24);
      wdt3  <= 34'(wdsum >>> 24);
      pv1_3 <= pv1_2;
      w3    <= w2;
    end
  end

  // Stage 4: new-gradient share of the second moment.
  logic [56:0]        pv2_4;
  logic [47:0]        pv1_4;
  logic signed [31:0] mn4, w4;
  logic signed [33:0] wdt4;
  logic [16:0]        b2n;

  assign b2n = ONE_Q16 - {1'b0, beta_second};

  always_ff @(posedge clk) begin
    if (en) begin
      pv2_4 <= b2n * g2_3;
      pv1_4 <= pv1_3;
      mn4   <= mn3;
      wdt4  <= wdt3;
      w4    <= w3;
    end
  end

  // Stage 5: round and clamp the second moment; from here side data rides along.
  side_t       side_q [5:K_DIV2_OUT];
  logic [57:0] vsum;
  logic [41:0] vsh;
  logic [31:0] vn5;

  assign vsum = 58'(pv1_4) + 58'(pv2_4) + 58'h8000;
  assign vsh  = 42'(vsum >> 16);
  assign vn5  = (vsh[41:32] != '0) ? '1 : vsh[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[5].w    <= w4;
      side_q[5].mn   <= mn4;
      side_q[5].vn   <= vn5;
      side_q[5].wdt  <= wdt4;
      side_q[5].mhat <= '0;
      side_q[5].neg  <= 1'b0;
      side_q[5].zero <= 1'b0;
    end
  end

  // Beta powers by square and multiply, one exponent bit per stage.
  pow_t pw [0:STEP_BITS-1];
  pow_t pw_init;

  function automatic pow_t pow_iter(input pow_t s);
    pow_t        o;
    logic [64:0] pa1, pa2;
    logic [63:0] pb1, pb2;
    pa1 = s.acc1 * s.base1;
    pa2 = s.acc2 * s.base2;
    pb1 = s.base1 * s.base1;
    pb2 = s.base2 * s.base2;
    o.acc1  = s.t[0] ? pa1[64:32] : s.acc1;
    o.acc2  = s.t[0] ? pa2[64:32] : s.acc2;
    o.base1 = pb1[63:32];
    o.base2 = pb2[63:32];
    o.t     = s.t >> 1;
    return o;
  endfunction

  always_comb begin
    pw_init.acc1  = ONE_Q32;
    pw_init.acc2  = ONE_Q32;
    pw_init.base1 = {beta_first, 16'd0};
    pw_init.base2 = {beta_second, 16'd0};
    pw_init.t     = t1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw[0] <= pow_iter(pw_init);
    end
  end

  for (genvar i = 1; i < STEP_BITS; i++) begin : g_pow
    always_ff @(posedge clk) begin
      if (en) begin
        pw[i] <= pow_iter(pw[i-1]);
      end
    end
  end

  // Bias-correction dividends: moment times 2^32 plus half the divisor.
  logic [63:0] n1, n2;
  logic [32:0] d1, d2;
  logic [32:0] d1_c, d2_c;
  logic [31:0] mmag;
  side_t       s_bc;

  assign s_bc = side_q[K_DIV1_IN-1];
  assign d1_c = ONE_Q32 - pw[STEP_BITS-1].acc1;
  assign d2_c = ONE_Q32 - pw[STEP_BITS-1].acc2;
  assign mmag = s_bc.mn[31] ? 32'(-s_bc.mn) : 32'(s_bc.mn);

  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= {mmag, 32'd0} + 64'(d1_c >> 1);
      n2 <= {s_bc.vn, 32'd0} + 64'(d2_c >> 1);
      d1 <= d1_c;
      d2 <= d2_c;
    end
  end

  logic [33:0] q1, q2;

  aou_div u_div_m (.clk(clk), .en(en), .num(n1), .den(d1), .quo(q1));
  aou_div u_div_v (.clk(clk), .en(en), .num(n2), .den(d2), .quo(q2));

  // Sign and clamp the corrected moments; the root input is v_hat + epsilon.
  logic signed [31:0] mhat_c;
  logic [31:0]        vhat_c;
  logic [32:0]        sq_in;

  always_comb begin
    if (side_q[K_SQ_IN-1].mn[31]) begin
      mhat_c = (q1 >= 34'h8000_0000) ? 32'sh8000_0000 : 32'(-q1[31:0]);
    end else begin
      mhat_c = (q1 > 34'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q1[31:0]);
    end
    vhat_c = (q2[33:32] != '0) ? '1 : q2[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_in <= 33'(vhat_c) + 33'(epsilon);
    end
  end

  logic [28:0] root;

  aou_sqrt u_sqrt (.clk(clk), .en(en), .x(sq_in), .root(root));

  // Step dividend: |m_hat| times 2^24 plus half the root.
  logic [63:0]        n3;
  logic [32:0]        d3;
  logic signed [31:0] mhat_r;
  logic [31:0]        hmag;

  assign mhat_r = side_q[K_DIV2_IN-1].mhat;
  assign hmag   = mhat_r[31] ? 32'(-mhat_r) : 32'(mhat_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n3 <= {8'd0, hmag, 24'd0} + 64'(root >> 1);
      d3 <= 33'(root);
    end
  end

  logic [33:0] q3;

  aou_div u_div_s (.clk(clk), .en(en), .num(n3), .den(d3), .quo(q3));

  // Side data delay line; fields are filled in where they are produced.
  for (genvar k = 6; k <= K_DIV2_OUT; k++) begin : g_side
    side_t side_d;

    always_comb begin
      side_d = side_q[k-1];
      if (k == K_SQ_IN) begin
        side_d.mhat = mhat_c;
      end
      if (k == K_DIV2_IN) begin
        side_d.neg  = mhat_r[31];
        side_d.zero = (root == '0);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k] <= side_d;
      end
    end
  end

  // Total step plus decay term, clamped.
  side_t              s_end;
  logic signed [35:0] step;
  logic signed [36:0] tsum;
  logic signed [31:0] total, w_t, mn_t;
  logic [31:0]        vn_t;

  assign s_end = side_q[K_DIV2_OUT];

  always_comb begin
    if (s_end.zero) begin
      step = '0;
    end else if (s_end.neg) begin
      step = -$signed({2'b00, q3});
    end else begin
      step = $signed({2'b00, q3});
    end
    tsum = 37'(step) + 37'(s_end.wdt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= sat_s32(41'(tsum));
      w_t   <= s_end.w;
      mn_t  <= s_end.mn;
      vn_t  <= s_end.vn;
    end
  end

  // Learning-rate product.
  logic signed [56:0] lrp;
  logic signed [31:0] w_l, mn_l;
  logic [31:0]        vn_l;

  always_ff @(posedge clk) begin
    if (en) begin
      lrp  <= $signed({1'b0, learning_rate}) * total;
      w_l  <= w_t;
      mn_l <= mn_t;
      vn_l <= vn_t;
    end
  end

  // Output register: weight minus the rounded step.
  logic signed [57:0] lrsum;
  logic signed [33:0] lr_r;
  logic signed [34:0] wsum;
  logic signed [31:0] wo, mo;
  logic [31:0]        vo;

  assign lrsum = 58'(lrp) + 58'sh80_0000;
  assign lr_r  = 34'(lrsum >>> 24);
  assign wsum  = 35'(w_l) - 35'(lr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      wo <= sat_s32(41'(wsum));
      mo <= mn_l;
      vo <= vn_l;
    end
  end

  assign m_tdata = {vo, mo, wo};

endmodule

// ----- rtl/core/aou_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a 64-bit dividend by a 33-bit divisor, one quotient bit per stage,
// and clamps the quotient to all ones when it does not fit in 34 bits.
// ----------------------------------------------------------------------------
module aou_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [33:0] quo
);
  import aou_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [33:0] low;
    logic [33:0] q;
    logic        ovf;
    logic [32:0] den;
  } div_stage_t;

  div_stage_t st [0:DIV_LAT-1];
  div_stage_t first;

  // One quotient bit: shift in the next dividend bit and try the subtract.
  function automatic div_stage_t div_iter(input div_stage_t s);
    div_stage_t o;
    logic [32:0] r;
    o = s;
    r = {s.rem, s.low[33]};
    if (r >= s.den) begin
      o.rem = 32'(r - s.den);
      o.q   = {s.q[32:0], 1'b1};
    end else begin
      o.rem = r[31:0];
      o.q   = {s.q[32:0], 1'b0};
    end
    o.low = {s.low[32:0], 1'b0};
    return o;
  endfunction

  // The top dividend bits form the first partial remainder; a quotient of
  // 2^34 or more is caught up front.
  always_comb begin
    first.rem = {2'b00, num[63:34]};
    first.low = num[33:0];
    first.q   = '0;
    first.ovf = {3'b000, num} >= {den, 34'd0};
    first.den = den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_iter(first);
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= div_iter(st[j-1]);
      end
    end
  end

  assign quo = st[DIV_LAT-1].ovf ? '1 : st[DIV_LAT-1].q;

endmodule

// ----- rtl/core/aou_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Returns floor(sqrt(x * 2^24)) for a 33-bit x, one root bit per stage.
// ----------------------------------------------------------------------------
module aou_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] x,
  output logic [28:0] root
);
  import aou_pkg::*;

  typedef struct packed {
    logic [30:0] rem;
    logic [28:0] root;
    logic [57:0] rest;
  } sqrt_stage_t;

  sqrt_stage_t st [0:SQRT_LAT-1];
  sqrt_stage_t first;

  // One root bit: bring down two radicand bits and try root*4+1.
  function automatic sqrt_stage_t sqrt_iter(input sqrt_stage_t s);
    sqrt_stage_t o;
    logic [32:0] r;
    logic [32:0] trial;
    o     = s;
    r     = {s.rem, s.rest[57:56]};
    trial = {2'b00, s.root, 2'b01};
    if (r >= trial) begin
      o.rem  = 31'(r - trial);
      o.root = {s.root[27:0], 1'b1};
    end else begin
      o.rem  = r[30:0];
      o.root = {s.root[27:0], 1'b0};
    end
    o.rest = {s.rest[55:0], 2'b00};
    return o;
  endfunction

  always_comb begin
    first.rem  = '0;
    first.root = '0;
    first.rest = {1'b0, x, 24'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sqrt_iter(first);
    end
  end

  for (genvar j = 1; j < SQRT_LAT; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= sqrt_iter(st[j-1]);
      end
    end
  end

  assign root = st[SQRT_LAT-1].root;

endmodule

// ----- rtl/core/aou_check.sv -----
// ----------------------------------------------------------------------------
// Adam update port checker
// Watches the stream ports of the update block over time.
// ----------------------------------------------------------------------------
module aou_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic [95:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // A waiting result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A waiting result keeps its data.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // New requests are taken exactly when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output side");

  // Reset leaves no result behind.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind adam_optimizer_update aou_check u_aou_check (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tdata(m_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready)
);

// ----- test/tb_adam_optimizer_update.sv -----
// ----------------------------------------------------------------------------
// Adam optimizer update testbench
// Drives parameter requests through the stream port, predicts every updated
// weight and moment pair in fixed point, and compares results field by field
// while both sides idle at random, under several register settings.
// ----------------------------------------------------------------------------
module tb_adam_optimizer_update;
  import aou_pkg::*;

  localparam int LATENCY   = STEP_BITS + 103;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1500;

  // One parameter request and its update.
  typedef struct packed {
    logic [15:0] step_count;
    logic [31:0] second_moment_in;
    logic [31:0] first_moment_in;
    logic [31:0] gradient;
    logic [31:0] weight_in;
  } param_req_t;

  typedef struct packed {
    logic [31:0] second_moment_out;
    logic [31:0] first_moment_out;
    logic [31:0] weight_out;
  } param_upd_t;

  // A directed row; the update is typed in only where has_upd is set.
  typedef struct {
    param_req_t req;
    bit         has_upd;
    param_upd_t upd;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [143:0] s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  m_tdata;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;

  // Local copy of the optimizer registers.
  logic [15:0] beta1_q, beta2_q;
  logic [23:0] lr_q, wd_q, eps_q;

  param_upd_t pending_upd[$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_recv = 1'b0;
  int         wdog = 0;
  bit         done = 1'b0;

  adam_optimizer_update dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Round to nearest with ties upward, dropping n bits (arithmetic shift floors).
  function automatic longint rnd_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Bias correction denominator 1 - beta^t in Q0.32.
  function automatic longint unsigned bias_denom(logic [15:0] beta, longint unsigned t);
    longint unsigned acc, base;
    acc = 64'd1 << 32;
    base = longint'(beta) << 16;
    for (int i = 0; i < STEP_BITS; i++) begin
      if ((t >> i) & 1) acc = (acc * base) >> 32;
      base = (base * base) >> 32;
    end
    return (64'd1 << 32) - acc;
  endfunction

  function automatic param_upd_t adam_update(param_req_t r);
    longint w, g, m, mn, mhat, step, total, wn, b1;
    longint unsigned v, t, gmag, g2, vn, d1, d2, mag, vhat, root, b2;
    param_upd_t u;
    w = longint'(signed'(r.weight_in));
    g = longint'(signed'(r.gradient));
    m = longint'(signed'(r.first_moment_in));
    v = r.second_moment_in;
    t = r.step_count & ((64'd1 << STEP_BITS) - 1);
    if (t == 0) t = 1;
    b1 = beta1_q;
    b2 = beta2_q;
    mn = sat32(rnd_shift(b1 * m + (65536 - b1) * g, 16));
    gmag = (g < 0) ? -g : g;
    g2 = (gmag * gmag + (64'd1 << 23)) >> 24;
    vn = (b2 * v + (65536 - b2) * g2 + (64'd1 << 15)) >> 16;
    if (vn > 64'hFFFF_FFFF) vn = 64'hFFFF_FFFF;
    d1 = bias_denom(beta1_q, t);
    d2 = bias_denom(beta2_q, t);
    mag = (mn < 0) ? -mn : mn;
    mag = ((mag << 32) + d1 / 2) / d1;
    if (mn < 0) mhat = (mag >= (64'd1 << 31)) ? -64'sd2147483648 : -longint'(mag);
    else mhat = (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
    vhat = ((vn << 32) + d2 / 2) / d2;
    if (vhat > 64'hFFFF_FFFF) vhat = 64'hFFFF_FFFF;
    root = int_sqrt((vhat + eps_q) << 24);
    // A zero root leaves the step term out.
    if (root == 0) begin
      step = 0;
    end else begin
      mag = (mhat < 0) ? -mhat : mhat;
      mag = ((mag << 24) + root / 2) / root;
      step = (mhat < 0) ? -longint'(mag) : longint'(mag);
    end
    total = sat32(step + rnd_shift(longint'(wd_q) * w, 24));
    wn = sat32(w - rnd_shift(longint'(lr_q) * total, 24));
    u.weight_out = wn[31:0];
    u.first_moment_out = mn[31:0];
    u.second_moment_out = vn[31:0];
    return u;
  endfunction

  // Register write while the pipeline is empty; index beyond the list is ignored.
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_BETA_FIRST:    beta1_q = val[15:0];
      REG_BETA_SECOND:   beta2_q = val[15:0];
      REG_LEARNING_RATE: lr_q = val;
      REG_WEIGHT_DECAY:  wd_q = val;
      REG_EPSILON:       eps_q = val;
      default: ;
    endcase
  endtask

  // Offer one request, idling first at random, and wait for its acceptance.
  task automatic send_req(param_req_t r);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tdata = r;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_upd = {pending_upd, adam_update(r)};
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending_upd.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_q824();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return {{8{1'b0}}, 24'($urandom)} ^ ({32{1'($urandom_range(1))}});
    endcase
  endfunction

  function automatic param_req_t rand_req();
    param_req_t r;
    r.weight_in = rand_q824();
    r.gradient = rand_q824();
    r.first_moment_in = rand_q824();
    r.second_moment_in = ($urandom_range(3) == 0) ? $urandom : {8'd0, 24'($urandom)};
    case ($urandom_range(3))
      0: r.step_count = 16'($urandom);
      1: r.step_count = 16'($urandom_range(0, 3));
      default: r.step_count = 16'($urandom_range(1, 200));
    endcase
    return r;
  endfunction

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    param_upd_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_upd.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected update %h", got);
      end else begin
        want = pending_upd.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("update mismatch: w %h/%h m %h/%h v %h/%h (expected/actual)",
                     want.weight_out, got.weight_out, want.first_moment_out,
                     got.first_moment_out, want.second_moment_out,
                     got.second_moment_out);
        end
      end
    end
  end

  // Receiver readiness, changed at the falling edge.
  always @(negedge clk) begin
    m_tready <= !rst && !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any accepted request or result while work waits.
  always @(posedge clk) begin
    if (rst || done || (s_tvalid && s_tready) || (m_tvalid && m_tready)
        || (pending_upd.size() == 0 && !s_tvalid)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("[adam_optimizer_update] ERROR");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    beta1_q = RST_BETA_FIRST;
    beta2_q = RST_BETA_SECOND;
    lr_q = RST_LEARNING_RATE;
    wd_q = RST_WEIGHT_DECAY;
    eps_q = RST_EPSILON;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: a request of zeros at step one gives an all-zero update.
    row = '{req: '{16'd1, 32'd0, 32'd0, 32'd0, 32'd0}, has_upd: 1'b1,
            upd: '{32'd0, 32'd0, 32'd0}};
    rows = {rows, row};
    // Step zero acts as step one; weight alone with no decay stays put.
    row = '{req: '{16'd0, 32'd0, 32'd0, 32'd0, 32'h0100_0000}, has_upd: 1'b1,
            upd: '{32'd0, 32'd0, 32'h0100_0000}};
    rows = {rows, row};
    row.has_upd = 1'b0;
    row.req = '{16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    rows = {rows, row};
    row.req = '{16'h8000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    rows = {rows, row};
    row.req = '{16'd1, 32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 32'hFF00_0000};
    rows = {rows, row};
    row.req = '{16'd2, 32'd0, 32'd0, 32'h0000_0001, 32'hFFFF_FFFF};
    rows = {rows, row};
    row.req = '{16'd3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001};
    rows = {rows, row};
    row.req = '{16'd100, 32'h1234_5678, 32'h0000_8000, 32'hFFFF_8000, 32'h0040_0000};
    rows = {rows, row};

    foreach (rows[i]) begin
      if (rows[i].has_upd && adam_update(rows[i].req) !== rows[i].upd) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send_req(rows[i].req);
    end
    drain();

    // Extreme settings: zero root case, full rates, zero first beta, all-ones second beta.
    write_reg(REG_EPSILON, 24'd0);
    write_reg(REG_LEARNING_RATE, 24'hFF_FFFF);
    write_reg(REG_WEIGHT_DECAY, 24'hFF_FFFF);
    write_reg(REG_BETA_FIRST, 24'h0);
    write_reg(REG_BETA_SECOND, 24'hAB_FFFF);
    write_reg(3'd7, 24'h12_3456);
    send_req('{16'd1, 32'd0, 32'd0, 32'd0, 32'h0100_0000});
    send_req('{16'd5, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_req('{16'd0, 32'd0, 32'hC000_0000, 32'd0, 32'h4000_0000});
    drain();

    // Random phases, each under a new register setting; the idling mix changes every two phases.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BETA_FIRST, (ph == 1) ? 24'hFFFF : 24'($urandom));
      write_reg(REG_BETA_SECOND, (ph == 2) ? 24'h0000 : 24'($urandom));
      write_reg(REG_LEARNING_RATE, (ph == 3) ? 24'd0 : 24'($urandom));
      write_reg(REG_WEIGHT_DECAY, (ph == 4) ? 24'd0 : 24'($urandom_range(0, 65535)));
      write_reg(REG_EPSILON, (ph == 5) ? 24'hFF_FFFF : 24'($urandom_range(1, 1000)));
      if (ph < 2) begin
        send_idle_pct = 15; recv_idle_pct = 81;
      end else if (ph < 4) begin
        send_idle_pct = 81; recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // Long receiver hold-off so the pipeline fills and stalls its input.
      if (ph == 4) begin
        fork
          begin
            hold_recv = 1'b1;
            repeat (400) @(negedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        send_req(rand_req());
        // Sender pause until every update has come back.
        if (ph == 5 && i == 50) while (pending_upd.size() != 0) @(negedge clk);
      end
      drain();
    end

    done = 1'b1;
    if (mismatches == 0 && pending_upd.size() == 0) begin
      $display("[adam_optimizer_update] OK");
    end else begin
      $display("[adam_optimizer_update] ERROR");
    end
    $finish;
  end

endmodule
